@@ design/hid_pkg.sv @@
package hid_pkg;

    localparam int TEXT_LIMIT_DEF  = 256;
    localparam int MAX_SYMBOLS_DEF = 26;

    localparam int HASH_W  = 64;
    localparam int BYTE_W  = 8;
    localparam int SYM_W   = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // 128-bit stream plus two zero pad bits so the final symbol reads cleanly
    localparam int SHIFT_W = 2 * HASH_W + 2;

    localparam logic [HASH_W-1:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
    // FNV-64 prime = 2^40 + 0x1B3
    localparam int                PRIME_SHIFT = 40;
    localparam logic [8:0]        PRIME_LO    = 9'h1B3;

    localparam logic [SYM_W-1:0]  ID_LENGTH_RESET = 5'd8;

    // register index carried by paddr[2]
    localparam logic              REG_ID_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_REHASH,
        S_EMIT,
        S_ERROR
    } t_state;

    // byte order reversal: lowest byte ends up in the top position
    function automatic logic [HASH_W-1:0] byte_reverse(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] r;
        r = '0;
        for (int i = 0; i < HASH_W / BYTE_W; i++) begin
            r[HASH_W-1-BYTE_W*i -: BYTE_W] = h[BYTE_W*i +: BYTE_W];
        end
        return r;
    endfunction

endpackage

@@ design/hashed_identifier_generator_core.sv @@
// Hashed identifier generator.
// Input channel (i_in_valid / o_in_stall): one key-text byte per transaction,
// i_is_last on the final byte. Each byte is folded into a 64-bit FNV-1a hash
// by one shared fold unit (xor, then multiply by the prime) in the cycle after
// it is taken; o_in_stall is high while the sequencer is busy.
// On the last byte the eight bytes of the hash are rehashed through the same
// fold unit, one byte per cycle. The symbols then enter the output register,
// one per cycle while the output is not stalled, and the input is freed once
// the last symbol is loaded. Output channel (o_out_valid / i_out_stall):
// symbol, last_symbol and overflow_error. While i_out_stall holds a valid
// symbol, the output register holds and the sequencer waits; a new byte may
// be taken while the final symbol still waits.
// A text that reaches TEXT_LIMIT bytes yields one error transaction instead.
// id_length (APB register 0) sets symbols per identifier, clamped to
// 1..MAX_SYMBOLS; write it only while idle.
// Reset: hash returns to the offset basis, byte count and too-long flag clear,
// id_length becomes 8. No clearing pass; the block is ready right after reset.
module hashed_identifier_generator_core #(
    parameter int TEXT_LIMIT  = hid_pkg::TEXT_LIMIT_DEF,
    parameter int MAX_SYMBOLS = hid_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [hid_pkg::BYTE_W-1:0]  i_text_byte,
    input  logic                        i_is_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [hid_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last_symbol,
    output logic                        o_overflow_error,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hid_pkg::PADDR_W-1:0] paddr,
    input  logic [hid_pkg::PDATA_W-1:0] pwdata,
    output logic [hid_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import hid_pkg::*;

    localparam int CNT_W = $clog2(TEXT_LIMIT + 1);

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_too_long, n_too_long;

    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic                r_last, n_last;
    logic [HASH_W-1:0]   r_hash2, n_hash2;
    logic [2:0]          r_round, n_round;
    logic [SHIFT_W-1:0]  r_shift, n_shift;
    logic [SYM_W-1:0]    r_sym_cnt, n_sym_cnt;
    logic [SYM_W-1:0]    r_symbol, n_symbol;
    logic                r_last_symbol, n_last_symbol;
    logic                r_overflow_error, n_overflow_error;

    logic [SYM_W-1:0]    w_id_length;
    logic [SYM_W-1:0]    w_sym_total;
    logic                w_out_free;
    logic                w_final_sym;
    logic [BYTE_W-1:0]   w_rehash_byte;
    logic [HASH_W-1:0]   w_fold_hash;
    logic [BYTE_W-1:0]   w_fold_byte;
    logic [HASH_W-1:0]   w_fold_out;

    hid_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_id_length (w_id_length)
    );

    hid_fold u_fold (
        .i_hash (w_fold_hash),
        .i_byte (w_fold_byte),
        .o_hash (w_fold_out)
    );

    always_comb begin
        if (w_id_length == '0) begin
            w_sym_total = SYM_W'(1);
        end else if (w_id_length > SYM_W'(MAX_SYMBOLS)) begin
            w_sym_total = SYM_W'(MAX_SYMBOLS);
        end else begin
            w_sym_total = w_id_length;
        end
    end

    assign w_rehash_byte = r_hash[{r_round, 3'b000} +: BYTE_W];
    assign w_fold_hash   = (r_state == S_REHASH) ? r_hash2 : r_hash;
    assign w_fold_byte   = (r_state == S_REHASH) ? w_rehash_byte : r_byte;
    assign w_out_free    = !r_out_valid || !i_out_stall;
    assign w_final_sym   = (r_sym_cnt == w_sym_total - SYM_W'(1));

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_symbol         = r_symbol;
    assign o_last_symbol    = r_last_symbol;
    assign o_overflow_error = r_overflow_error;

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid;
        n_hash           = r_hash;
        n_count          = r_count;
        n_too_long       = r_too_long;
        n_byte           = r_byte;
        n_last           = r_last;
        n_hash2          = r_hash2;
        n_round          = r_round;
        n_shift          = r_shift;
        n_sym_cnt        = r_sym_cnt;
        n_symbol         = r_symbol;
        n_last_symbol    = r_last_symbol;
        n_overflow_error = r_overflow_error;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_byte  = i_text_byte;
                    n_last  = i_is_last;
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                // once too long, bytes are dropped until the last mark
                if (!r_too_long) begin
                    n_hash     = w_fold_out;
                    n_count    = r_count + CNT_W'(1);
                    n_too_long = (n_count == CNT_W'(TEXT_LIMIT));
                end
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (n_too_long) begin
                    n_state = S_ERROR;
                end else begin
                    n_hash2 = HASH_BASIS;
                    n_round = '0;
                    n_state = S_REHASH;
                end
            end
            S_REHASH: begin
                n_hash2 = w_fold_out;
                n_round = r_round + 3'd1;
                if (r_round == 3'd7) begin
                    n_shift    = {byte_reverse(r_hash), byte_reverse(w_fold_out), 2'b00};
                    n_sym_cnt  = '0;
                    n_hash     = HASH_BASIS;
                    n_count    = '0;
                    n_too_long = 1'b0;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_symbol         = r_shift[SHIFT_W-1 -: SYM_W];
                    n_last_symbol    = w_final_sym;
                    n_overflow_error = 1'b0;
                    n_shift          = {r_shift[SHIFT_W-SYM_W-1:0], {SYM_W{1'b0}}};
                    n_sym_cnt        = r_sym_cnt + SYM_W'(1);
                    if (w_final_sym) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ERROR: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_symbol         = '0;
                    n_last_symbol    = 1'b1;
                    n_overflow_error = 1'b1;
                    n_hash           = HASH_BASIS;
                    n_count          = '0;
                    n_too_long       = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_hash      <= HASH_BASIS;
            r_count     <= '0;
            r_too_long  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_hash      <= n_hash;
            r_count     <= n_count;
            r_too_long  <= n_too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte           <= n_byte;
        r_last           <= n_last;
        r_hash2          <= n_hash2;
        r_round          <= n_round;
        r_shift          <= n_shift;
        r_sym_cnt        <= n_sym_cnt;
        r_symbol         <= n_symbol;
        r_last_symbol    <= n_last_symbol;
        r_overflow_error <= n_overflow_error;
    end

    a_too_long_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_too_long == (r_count == CNT_W'(TEXT_LIMIT)))
        else $error("too_long flag out of step with byte count");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TEXT_LIMIT))
        else $error("byte count past limit");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_sym_cnt < w_sym_total))
        else $error("symbol counter past identifier length");

    a_rehash_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REHASH && r_round == 3'd7) |=> (r_state == S_EMIT))
        else $error("rehash did not hand over to emission");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_overflow_error) |-> (r_last_symbol && r_symbol == '0))
        else $error("malformed overflow transaction");

endmodule

@@ design/hid_fold.sv @@
module hid_fold (
    input  logic [hid_pkg::HASH_W-1:0] i_hash,
    input  logic [hid_pkg::BYTE_W-1:0] i_byte,
    output logic [hid_pkg::HASH_W-1:0] o_hash
);
    import hid_pkg::*;

    logic [HASH_W-1:0]   w_x;
    logic [HASH_W+8:0]   w_prod;

    assign w_x    = i_hash ^ {{(HASH_W-BYTE_W){1'b0}}, i_byte};
    // x * prime mod 2^64 = x * 0x1B3 + (x << 40)
    assign w_prod = (HASH_W+9)'(w_x) * (HASH_W+9)'(PRIME_LO);
    assign o_hash = w_prod[HASH_W-1:0]
                  + {w_x[HASH_W-PRIME_SHIFT-1:0], {PRIME_SHIFT{1'b0}}};

endmodule

@@ design/hid_cfg.sv @@
module hid_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hid_pkg::PADDR_W-1:0] paddr,
    input  logic [hid_pkg::PDATA_W-1:0] pwdata,
    output logic [hid_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output logic [hid_pkg::SYM_W-1:0]   o_id_length
);
    import hid_pkg::*;

    logic [SYM_W-1:0] r_id_length;
    logic             w_hit;

    assign w_hit       = (paddr[2] == REG_ID_LENGTH);
    assign pready      = 1'b1;
    assign prdata      = w_hit ? {{(PDATA_W-SYM_W){1'b0}}, r_id_length} : '0;
    assign o_id_length = r_id_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_length <= ID_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_id_length <= pwdata[SYM_W-1:0];
        end
    end

endmodule
